### rtl/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants for the byte-wide ElGamal cipher.
// ----------------------------------------------------------------------------
package ebc_pkg;

	localparam int REG_W = 32;

	// status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BYTE    = 2'd1,
		ST_NOINV   = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	// register indexes
	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_GEN     = 2'd1;
	localparam logic [1:0] REG_PUB     = 2'd2;
	localparam logic [1:0] REG_PRIV    = 2'd3;

	localparam int BYTE_MAX = 255;

endpackage

### rtl/elgamal_byte_cipher.sv
// ----------------------------------------------------------------------------
// elgamal_byte_cipher
// ElGamal encrypt / decrypt of one byte per word over a prime modulus.
// ----------------------------------------------------------------------------
// One word is worked at a time; in_stall is high from acceptance until the
// result word is loaded into the output register. Every modular product runs
// through one shared shift-and-add unit, one bit of the multiplier per cycle.
// An exponentiation runs until the exponent is used up: each exponent bit costs
// a square, a multiply when the bit is set, and a pass through the sequencer
// states S_EXPB and S_SQR. An encrypt with a full 32-bit nonce spends most of
// its time in the two exponentiations. A decrypt runs a^x, one Euclid step
// per quotient (a shift-subtract divider, up to about 47 steps), then a
// reduction of b and one more product. Short exponents finish sooner. The
// output register lets the next word be accepted while a result still waits.
module elgamal_byte_cipher #(
	parameter int MOD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// input words
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     operation,
	input  logic [7:0]               plain_byte,
	input  logic [31:0]              nonce,
	input  logic [31:0]              cipher_first,
	input  logic [31:0]              cipher_second,
	// result words
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               plain_out,
	output logic [31:0]              cipher_first_out,
	output logic [31:0]              cipher_second_out,
	output ebc_pkg::status_t         status
);
	import ebc_pkg::*;

	localparam int W  = MOD_WIDTH;
	localparam int CW = W + 2;     // signed Euclid coefficient width
	localparam int CNT_W = $clog2(REG_W + 1);

	// sequencer states
	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_START = 14'b00000000000010,
		S_RBASE = 14'b00000000000100,
		S_EXPB  = 14'b00000000001000,
		S_ACCM  = 14'b00000000010000,
		S_SQR   = 14'b00000000100000,
		S_NEXT  = 14'b00000001000000,
		S_DIV   = 14'b00000010000000,
		S_EUC   = 14'b00000100000000,
		S_INVF  = 14'b00001000000000,
		S_FMUL  = 14'b00010000000000,
		S_DONE  = 14'b00100000000000,
		S_RCB   = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	// phases of the item
	typedef enum logic [2:0] {
		PH_GK  = 3'd0,   // g^k
		PH_YK  = 3'd1,   // y^k
		PH_MB  = 3'd2,   // m*y^k
		PH_AX  = 3'd3,   // a^x
		PH_INV = 3'd4,   // euclid
		PH_BS  = 3'd5    // b*s^-1
	} phase_t;

	state_t   state_q;
	phase_t   phase_q;

	logic [31:0]     mod_q, gen_q, pub_q, priv_q;
	logic            op_q;
	logic [7:0]      m_q;
	logic [31:0]     k_q, ca_q, cb_q;
	logic [W-1:0]    p_q;

	// exponentiation registers
	logic [W-1:0]    base_q, acc_q, fa_q, s_q;
	logic [31:0]     e_q;

	// shared modular multiplier: r = u*v mod p, one v bit per cycle
	logic [W-1:0]    mu_q, mv_q, mr_q;
	logic [CNT_W-1:0] cnt_q;
	logic            mul_sel_q;   // 0 result to acc, 1 result to base

	// divider (shared for reductions and Euclid): r0 = q*r1 + rem
	logic [31:0]     dn_q;        // numerator shifting out
	logic [W-1:0]    dd_q;        // divisor
	logic [W:0]      drem_q;
	logic [31:0]     dquo_q;

	// Euclid registers
	logic [W-1:0]    r0_q, r1_q;
	logic signed [CW-1:0] c0_q, c1_q;

	// output register
	logic            ov_q;
	logic [7:0]      po_q;
	logic [31:0]     fao_q, fbo_q;
	status_t         st_q;

	// multiplier step
	logic [W:0]      mr_dbl, mr_sub1, mr_add, mr_next;
	always_comb begin
		mr_dbl  = {mr_q, 1'b0};
		mr_sub1 = (mr_dbl >= {1'b0, p_q}) ? mr_dbl - {1'b0, p_q} : mr_dbl;
		mr_add  = mr_sub1 + {1'b0, mu_q};
		if (mv_q[W-1])
			mr_next = (mr_add >= {1'b0, p_q}) ? mr_add - {1'b0, p_q} : mr_add;
		else
			mr_next = mr_sub1;
	end

	// divider step
	logic [W+1:0]    dtry;
	logic [W:0]      drem_next;
	logic            dbit;
	always_comb begin
		dtry = {drem_q, dn_q[31]} - {2'b00, dd_q};
		dbit = !dtry[W+1];
		drem_next = dbit ? dtry[W:0] : {drem_q[W-1:0], dn_q[31]};
	end

	// Euclid coefficient update c2 = c0 - q*c1 (q and c1 bounded by p)
	logic signed [CW+32:0] qc;
	logic signed [CW-1:0]  c2;
	always_comb begin
		qc = $signed({1'b0, dquo_q}) * c1_q;
		c2 = c0_q - qc[CW-1:0];
	end

	// final inverse normalisation
	logic signed [CW-1:0] cfix;
	always_comb begin
		cfix = c0_q;
		if (c0_q < 0)
			cfix = c0_q + $signed({{(CW-W){1'b0}}, p_q});
	end

	logic in_acc, out_acc, cfg_wr;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = ov_q && !out_stall;
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign in_stall = (state_q != S_IDLE);

	// register read
	always_comb begin
		unique case (paddr[3:2])
			REG_MODULUS: prdata = mod_q;
			REG_GEN:     prdata = gen_q;
			REG_PUB:     prdata = pub_q;
			REG_PRIV:    prdata = priv_q;
			default:     prdata = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= 32'd257;
			gen_q  <= 32'd3;
			pub_q  <= 32'd1;
			priv_q <= 32'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODULUS: mod_q  <= pwdata & 32'((64'd1 << W) - 64'd1);
				REG_GEN:     gen_q  <= pwdata & 32'((64'd1 << W) - 64'd1);
				REG_PUB:     pub_q  <= pwdata & 32'((64'd1 << W) - 64'd1);
				REG_PRIV:    priv_q <= pwdata & 32'((64'd1 << W) - 64'd1);
				default:     ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (out_acc)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q  <= operation;
						m_q   <= plain_byte;
						k_q   <= nonce;
						ca_q  <= cipher_first;
						cb_q  <= cipher_second;
						p_q   <= W'(mod_q);
						state_q <= S_START;
					end
				end
				S_START: begin
					fa_q <= '0;
					po_q <= '0; fao_q <= '0; fbo_q <= '0; st_q <= ST_OK;
					if (!op_q) begin
						if (W'(m_q) >= p_q) begin
							st_q <= ST_BYTE;
							state_q <= S_DONE;
						end else if (p_q < W'(2)) begin
							state_q <= S_DONE;
						end else begin
							phase_q <= PH_GK;
							dn_q <= gen_q; state_q <= S_RBASE;
							dd_q <= p_q; drem_q <= '0; cnt_q <= '0;
						end
					end else begin
						if (p_q == '0) begin
							st_q <= ST_NOINV; state_q <= S_DONE;
						end else if (p_q == W'(1)) begin
							state_q <= S_DONE;
						end else begin
							phase_q <= PH_AX;
							dn_q <= ca_q; state_q <= S_RBASE;
							dd_q <= p_q; drem_q <= '0; cnt_q <= '0;
						end
					end
				end
				// base mod p by the divider, one bit a cycle
				S_RBASE: begin
					drem_q <= drem_next;
					dn_q   <= {dn_q[30:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(31)) begin
						base_q <= drem_next[W-1:0];
						acc_q  <= W'(1);
						e_q <= (phase_q == PH_AX) ? priv_q : k_q;
						state_q <= S_EXPB;
					end
				end
				// square and multiply over exponent bits
				S_EXPB: begin
					if (e_q == '0) begin
						state_q <= S_NEXT;
					end else if (e_q[0]) begin
						mu_q <= acc_q; mv_q <= base_q; mr_q <= '0;
						cnt_q <= '0; mul_sel_q <= 1'b0; state_q <= S_ACCM;
					end else begin
						mu_q <= base_q; mv_q <= base_q; mr_q <= '0;
						cnt_q <= '0; mul_sel_q <= 1'b1; state_q <= S_ACCM;
					end
				end
				S_ACCM: begin
					mr_q <= mr_next[W-1:0];
					mv_q <= {mv_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W - 1)) begin
						if (!mul_sel_q) begin
							acc_q <= mr_next[W-1:0];
							mu_q <= base_q; mv_q <= base_q; mr_q <= '0;
							cnt_q <= '0; mul_sel_q <= 1'b1;
						end else begin
							base_q <= mr_next[W-1:0];
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					e_q <= {1'b0, e_q[31:1]};
					state_q <= S_EXPB;
				end
				// phase hand-over
				S_NEXT: begin
					unique case (phase_q)
						PH_GK: begin
							fa_q <= acc_q; phase_q <= PH_YK;
							dn_q <= pub_q; dd_q <= p_q; drem_q <= '0;
							cnt_q <= '0; state_q <= S_RBASE;
						end
						PH_YK: begin
							phase_q <= PH_MB;
							mu_q <= W'(m_q); mv_q <= acc_q; mr_q <= '0;
							cnt_q <= '0; state_q <= S_FMUL;
						end
						PH_AX: begin
							s_q <= acc_q;
							r0_q <= acc_q; r1_q <= p_q;
							c0_q <= CW'(1); c1_q <= '0;
							phase_q <= PH_INV; state_q <= S_EUC;
						end
						default: state_q <= S_DONE;
					endcase
				end
				// Euclid: one division per step
				S_EUC: begin
					if (r1_q == '0) begin
						state_q <= S_INVF;
					end else begin
						dn_q <= 32'(r0_q); dd_q <= r1_q; drem_q <= '0;
						dquo_q <= '0; cnt_q <= '0; state_q <= S_DIV;
					end
				end
				S_DIV: begin
					drem_q <= drem_next;
					dn_q   <= {dn_q[30:0], 1'b0};
					dquo_q <= {dquo_q[30:0], dbit};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(31)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					r0_q <= r1_q; r1_q <= drem_q[W-1:0];
					c0_q <= c1_q; c1_q <= c2;
					state_q <= S_EUC;
				end
				S_INVF: begin
					if (r0_q != W'(1)) begin
						st_q <= ST_NOINV; state_q <= S_DONE;
					end else begin
						// reduce b by p first
						dn_q <= cb_q; dd_q <= p_q; drem_q <= '0;
						cnt_q <= '0; s_q <= cfix[W-1:0];
						state_q <= S_RCB;
					end
				end
				S_RCB: begin
					drem_q <= drem_next;
					dn_q   <= {dn_q[30:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(31)) begin
						phase_q <= PH_BS;
						mu_q <= drem_next[W-1:0]; mv_q <= s_q; mr_q <= '0;
						cnt_q <= '0; state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					mr_q <= mr_next[W-1:0];
					mv_q <= {mv_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W - 1)) begin
						if (phase_q == PH_MB) begin
							fao_q <= 32'(fa_q);
							fbo_q <= 32'(mr_next[W-1:0]);
						end else if (mr_next[W-1:0] > W'(BYTE_MAX)) begin
							st_q <= ST_RANGE;
						end else begin
							po_q <= mr_next[7:0];
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ov_q || out_acc) begin
						ov_q <= 1'b1;
						plain_out <= po_q;
						cipher_first_out <= fao_q;
						cipher_second_out <= fbo_q;
						status <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;

	// ---- assertions ----
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accepting while busy");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> (ov_q && $stable(status)))
		else $error("result lost under stall");

endmodule

### dv/elgamal_byte_cipher_tb.sv
// ----------------------------------------------------------------------------
// elgamal_byte_cipher_tb
// Self-checking bench for the byte-wide ElGamal cipher. Words are driven from
// a pending queue with bursty gaps, results are checked against an in-bench
// predictor of the encrypt and decrypt arithmetic, across several key sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elgamal_byte_cipher_tb;
	import ebc_pkg::*;

	localparam int          WATCHDOG_LIMIT = 60000;
	localparam int          DRAIN_CYCLES   = 40;
	localparam logic [31:0] PRIME_BIG      = 32'hFFFF_FFFB;

	typedef struct {
		logic        operation;
		logic [7:0]  plain_byte;
		logic [31:0] nonce;
		logic [31:0] cipher_first;
		logic [31:0] cipher_second;
	} cipher_word_t;

	typedef struct {
		logic [7:0]  plain_out;
		logic [31:0] cipher_first_out;
		logic [31:0] cipher_second_out;
		status_t     status;
	} cipher_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [7:0]  plain_byte = '0;
	logic [31:0] nonce = '0, cipher_first = '0, cipher_second = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  plain_out;
	logic [31:0] cipher_first_out, cipher_second_out;
	status_t     status;

	// copy of the key registers as last written
	logic [31:0] cfg_mod = 32'd257, cfg_gen = 32'd3, cfg_pub = 32'd1, cfg_priv = 32'd0;

	cipher_word_t   words_pending[$];
	cipher_result_t results_due[$];
	int             n_errors = 0;
	int             hold_left = 0;

	elgamal_byte_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.plain_byte(plain_byte), .nonce(nonce), .cipher_first(cipher_first),
		.cipher_second(cipher_second),
		.out_valid(out_valid), .out_stall(out_stall), .plain_out(plain_out),
		.cipher_first_out(cipher_first_out), .cipher_second_out(cipher_second_out),
		.status(status)
	);

	always #5 clk = ~clk;

	// ---------------- arithmetic ----------------
	function automatic longint unsigned mulmod(longint unsigned u, longint unsigned v,
			longint unsigned p);
		return (u * v) % p;
	endfunction

	function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
			longint unsigned p);
		longint unsigned acc;
		if (p <= 1) return 0;
		acc = 1;
		b = b % p;
		while (e != 0) begin
			if (e[0]) acc = mulmod(acc, b, p);
			b = mulmod(b, b, p);
			e = e >> 1;
		end
		return acc;
	endfunction

	// extended Euclid; returns 0 when s has no inverse mod p
	function automatic bit invmod(longint unsigned s, longint unsigned p,
			output longint unsigned inv);
		longint unsigned r0, r1, q, rr;
		longint c0, c1, c2, mag;
		r0 = s; r1 = p; c0 = 1; c1 = 0; inv = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			rr = r0 % r1;
			c2 = c0 - longint'(q) * c1;
			r0 = r1; r1 = rr;
			c0 = c1; c1 = c2;
		end
		if (r0 != 1) return 0;
		if (c0 < 0) begin
			mag = (-c0) % longint'(p);
			inv = (mag == 0) ? 0 : p - longint'(mag);
		end else
			inv = longint'(c0) % p;
		return 1;
	endfunction

	function automatic cipher_result_t predict_cipher(cipher_word_t w);
		cipher_result_t  r;
		longint unsigned p, s, sinv, m;
		p = cfg_mod;
		r = '{8'd0, 32'd0, 32'd0, ST_OK};
		if (w.operation == 1'b0) begin
			if (w.plain_byte >= p) r.status = ST_BYTE;
			else if (p >= 2) begin
				r.cipher_first_out  = 32'(powmod(cfg_gen, w.nonce, p));
				r.cipher_second_out = 32'(mulmod(w.plain_byte,
					powmod(cfg_pub, w.nonce, p), p));
			end
		end else if (p == 0) begin
			r.status = ST_NOINV;
		end else if (p >= 2) begin
			s = powmod(w.cipher_first, cfg_priv, p);
			if (!invmod(s, p, sinv)) r.status = ST_NOINV;
			else begin
				m = mulmod(w.cipher_second % p, sinv, p);
				if (m > BYTE_MAX) r.status = ST_RANGE;
				else r.plain_out = m[7:0];
			end
		end
		return r;
	endfunction

	// ---------------- report ----------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	// ---------------- driver ----------------
	bit word_taken = 0;
	int burst_left = 0, gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			results_due.insert(results_due.size(),
				predict_cipher(words_pending.pop_front()));
			word_taken <= 1'b1;
		end else
			word_taken <= 1'b0;
	end

	always @(negedge clk) begin
		logic nv;
		nv = in_valid;
		if (arst_n && (!in_valid || word_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) gap_left--;
			else if (words_pending.size() > 0) begin
				nv = 1'b1;
				operation     <= words_pending[0].operation;
				plain_byte    <= words_pending[0].plain_byte;
				nonce         <= words_pending[0].nonce;
				cipher_first  <= words_pending[0].cipher_first;
				cipher_second <= words_pending[0].cipher_second;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 6);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end
		end
		in_valid <= nv;
	end

	// ---------------- receiver stall ----------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		cipher_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result word", 32'd1, 32'd0);
			end else begin
				want = results_due.pop_front();
				if (plain_out !== want.plain_out)
					report_mismatch("plain_out", plain_out, want.plain_out);
				if (cipher_first_out !== want.cipher_first_out)
					report_mismatch("cipher_first_out", cipher_first_out, want.cipher_first_out);
				if (cipher_second_out !== want.cipher_second_out)
					report_mismatch("cipher_second_out", cipher_second_out,
						want.cipher_second_out);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	// ---------------- watchdog ----------------
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------- stimulus ----------------
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MODULUS: cfg_mod  = val;
			REG_GEN:     cfg_gen  = val;
			REG_PUB:     cfg_pub  = val;
			REG_PRIV:    cfg_priv = val;
			default:     ;
		endcase
	endtask

	task automatic load_keys(logic [31:0] p, logic [31:0] g, logic [31:0] x);
		reg_write(REG_MODULUS, p);
		reg_write(REG_GEN, g);
		reg_write(REG_PRIV, x);
		reg_write(REG_PUB, 32'(powmod(g, x, p)));
	endtask

	task automatic add_word(logic op, logic [7:0] m, logic [31:0] k, logic [31:0] a,
			logic [31:0] b);
		cipher_word_t w;
		w = '{op, m, k, a, b};
		words_pending.insert(words_pending.size(), w);
	endtask

	// encrypt, decrypt of a genuine pair, or noise
	task automatic add_random(int n);
		int          sel;
		logic [7:0]  m;
		logic [31:0] k, a, b;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			m   = 8'($urandom_range(0, 255));
			k   = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(1, 300);
			a   = $urandom();
			b   = $urandom();
			if (sel < 4) add_word(1'b0, m, k, a, b);
			else if (sel < 8) begin
				if (cfg_mod > 1) m = 8'(m % cfg_mod);
				add_word(1'b1, 8'($urandom()), $urandom(),
					32'(powmod(cfg_gen, k, cfg_mod)),
					32'(mulmod(m, powmod(cfg_pub, k, cfg_mod), cfg_mod)));
			end else add_word(1'b1, m, k, a, b);
		end
	endtask

	task automatic drain();
		wait (words_pending.size() == 0 && results_due.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset keys (x = 0, y = 1), then a real key at p = 257
		add_word(1'b0, 8'd0, 32'd0, 32'd0, 32'd0);
		add_word(1'b1, 8'd0, 32'd0, 32'd5, 32'd200);
		drain();
		load_keys(32'd257, 32'd3, 32'd77);
		add_word(1'b0, 8'd0, 32'd0, '0, '0);
		add_word(1'b0, 8'd255, 32'hFFFF_FFFF, '0, '0);
		add_word(1'b0, 8'd128, 32'd1, '0, '0);
		add_word(1'b0, 8'd1, 32'd255, '0, '0);
		add_word(1'b1, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd7);
		add_word(1'b1, 8'd0, 32'd0, 32'd257, 32'd3);
		add_word(1'b1, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(1'b1, 8'd0, 32'd0, 32'd1, 32'd256);
		add_word(1'b1, 8'd0, 32'd0, 32'(powmod(3, 9, 257)),
			32'(mulmod(200, powmod(cfg_pub, 9, 257), 257)));
		drain();
		// small modulus: bytes not below p, and the private key at its maximum
		load_keys(32'd2, 32'd1, 32'hFFFF_FFFF);
		add_word(1'b0, 8'd1, 32'd5, '0, '0);
		add_word(1'b0, 8'd2, 32'd5, '0, '0);
		add_word(1'b1, 8'd0, 32'd0, 32'd3, 32'd1);
		add_word(1'b1, 8'd0, 32'd0, 32'd2, 32'd1);
		drain();
		// modulus one and modulus zero
		reg_write(REG_MODULUS, 32'd1);
		add_word(1'b0, 8'd0, 32'd9, '0, '0);
		add_word(1'b0, 8'd1, 32'd9, '0, '0);
		add_word(1'b1, 8'd0, 32'd0, 32'd5, 32'd5);
		drain();
		reg_write(REG_MODULUS, 32'd0);
		add_word(1'b0, 8'd0, 32'd9, '0, '0);
		add_word(1'b1, 8'd0, 32'd0, 32'd5, 32'd5);
		drain();

		// random phases; the long hold outlasts two full words so the block backs up
		load_keys(32'd257, 32'd3, $urandom_range(1, 255));
		hold_left = 12000;
		add_random(35);
		drain();
		load_keys(PRIME_BIG, 32'd2, $urandom());
		add_random(50);
		drain();
		load_keys(32'hFFFF_FFFF, 32'd0, $urandom());
		add_random(20);
		drain();
		load_keys(32'd263, 32'd5, $urandom_range(1, 261));
		add_random(25);
		drain();

		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
